### rtl/tgjt_pkg.sv
// ----------------------------------------------------------------------------
// tgjt_pkg
// Shared command and status codes and the per-cycle control word that the
// job table top level drives into every cell of the row.
// ----------------------------------------------------------------------------
package tgjt_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_READ   = 2'd3
	} tgjt_cmd_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_DUP  = 2'd1,
		ST_MISS = 2'd2,
		ST_FULL = 2'd3
	} tgjt_status_t;

	typedef struct packed {
		logic ins_en;
		logic rem_en;
	} tgjt_ctrl_t;

endpackage

### rtl/type_grouped_job_table.sv
// ----------------------------------------------------------------------------
// type_grouped_job_table
// Ordered job table kept grouped by ascending type, with insert, remove,
// clear and read commands.
// ----------------------------------------------------------------------------
// Each command is registered in a command stage; then the row of TABLE_DEPTH
// cells compares every slot with the key in parallel, updates the table and
// registers one result. A new command is taken every cycle as long as results
// are drained; the cycle time is set by the per-cell compare plus the log-depth
// prefix that finds the cells behind a removed entry. Table contents are not
// cleared at reset; only the entry count and the valid flags are, and slots at
// or above the count are never read.
module type_grouped_job_table #(
	parameter int TABLE_DEPTH = 16,
	parameter int COORD_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            command,
	input  logic [1:0]            job_type,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [3:0]            read_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [4:0]            entry_count,
	output logic [1:0]            out_type,
	output logic [COORD_BITS-1:0] out_x,
	output logic [COORD_BITS-1:0] out_y
);
	import tgjt_pkg::*;

	localparam int EntryW = 2*COORD_BITS + 2;
	localparam int CntW   = $clog2(TABLE_DEPTH + 1);
	localparam int Levels = $clog2(TABLE_DEPTH);

	logic                  valid_s1;
	tgjt_cmd_t             cmd_s1;
	logic [1:0]            type_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;
	logic [3:0]            idx_s1;

	logic [CntW-1:0]       count_q;
	logic                  out_valid_q;
	tgjt_status_t          status_q;
	logic [4:0]            count_out_q;
	logic [EntryW-1:0]     rd_q;

	logic                  in_fire;
	logic                  advance;
	logic [EntryW-1:0]     key;
	logic [EntryW-1:0]     ents [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] ge_vec;
	logic [TABLE_DEPTH-1:0] match_vec;
	logic [TABLE_DEPTH-1:0] occ_vec;
	logic [TABLE_DEPTH-1:0] hit_vec;
	logic                  found;
	logic                  full;
	logic                  rd_ok;
	logic [EntryW-1:0]     rd_data;
	tgjt_ctrl_t            ctrl;
	tgjt_status_t          status_d;
	logic [CntW-1:0]       count_d;

	assign in_fire  = in_valid && in_ready;
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign key      = {type_s1, x_s1, y_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1  <= tgjt_cmd_t'(command);
			type_s1 <= job_type;
			x_s1    <= pos_x;
			y_s1    <= pos_y;
			idx_s1  <= read_index;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			logic [EntryW-1:0] left_e;
			logic [EntryW-1:0] right_e;
			logic              prev_ge;

			assign occ_vec[gi] = (int'(count_q) > gi);

			if (gi == 0) begin : g_first
				assign left_e  = key;
				assign prev_ge = 1'b0;
			end else begin : g_mid
				assign left_e  = ents[gi-1];
				assign prev_ge = ge_vec[gi-1];
			end

			if (gi == TABLE_DEPTH - 1) begin : g_last
				assign right_e = ents[gi];
			end else begin : g_inner
				assign right_e = ents[gi+1];
			end

			tgjt_cell #(
				.COORD_BITS(COORD_BITS)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.key        (key),
				.occupied   (occ_vec[gi]),
				.prev_ge    (prev_ge),
				.hit_before (hit_vec[gi]),
				.left_entry (left_e),
				.right_entry(right_e),
				.entry      (ents[gi]),
				.ge         (ge_vec[gi]),
				.match      (match_vec[gi])
			);
		end
	endgenerate

	always_comb begin
		logic [TABLE_DEPTH-1:0] pre;
		pre = match_vec;
		for (int l = 0; l < Levels; l++) begin
			pre = pre | (pre << (1 << l));
		end
		hit_vec = pre << 1;
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (int'(idx_s1) == i) begin
				rd_data = rd_data | ents[i];
			end
		end
	end

	assign found = |match_vec;
	assign full  = (int'(count_q) >= TABLE_DEPTH);
	assign rd_ok = (int'(idx_s1) < int'(count_q));

	always_comb begin
		ctrl     = '0;
		status_d = ST_DONE;
		count_d  = count_q;
		unique case (cmd_s1)
			CMD_INSERT: begin
				if (found) begin
					status_d = ST_DUP;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.ins_en = advance;
					count_d     = count_q + CntW'(1);
				end
			end
			CMD_REMOVE: begin
				if (found) begin
					ctrl.rem_en = advance;
					count_d     = count_q - CntW'(1);
				end else begin
					status_d = ST_MISS;
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			CMD_READ: begin
				if (!rd_ok) begin
					status_d = ST_MISS;
				end
			end
			default: begin
				status_d = ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q    <= status_d;
			count_out_q <= 5'(count_d);
			rd_q        <= (cmd_s1 == CMD_READ && rd_ok) ? rd_data : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = count_out_q;
	assign out_type    = rd_q[EntryW-1 -: 2];
	assign out_x       = rd_q[2*COORD_BITS-1 -: COORD_BITS];
	assign out_y       = rd_q[COORD_BITS-1:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= TABLE_DEPTH)
		else $error("entry count above table depth");

	a_no_dup_entries: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(match_vec))
		else $error("more than one stored entry matches the key");

	a_type_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (((~ge_vec) & (ge_vec << 1)) == '0))
		else $error("table entries out of type order");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins_en |=> count_q == $past(count_q) + CntW'(1))
		else $error("insert did not advance the entry count");

endmodule

### rtl/tgjt_cell.sv
// ----------------------------------------------------------------------------
// tgjt_cell
// One slot of the job table. Holds one (type, x, y) entry, compares it with
// the command key and shifts toward or away from its neighbors.
// ----------------------------------------------------------------------------
module tgjt_cell #(
	parameter int COORD_BITS = 8
) (
	input  logic                     clk,
	input  tgjt_pkg::tgjt_ctrl_t     ctrl,
	input  logic [2*COORD_BITS+1:0]  key,
	input  logic                     occupied,
	input  logic                     prev_ge,
	input  logic                     hit_before,
	input  logic [2*COORD_BITS+1:0]  left_entry,
	input  logic [2*COORD_BITS+1:0]  right_entry,
	output logic [2*COORD_BITS+1:0]  entry,
	output logic                     ge,
	output logic                     match
);
	import tgjt_pkg::*;

	localparam int TypeMsb = 2*COORD_BITS + 1;

	logic [TypeMsb:0] entry_q;

	always_comb begin
		ge    = !occupied || (entry_q[TypeMsb -: 2] >= key[TypeMsb -: 2]);
		match = occupied && (entry_q == key);
	end

	// insert: first cell at or above key type takes the key, later ones shift up
	// remove: matching cell and all above it take the right neighbor
	always_ff @(posedge clk) begin
		priority if (ctrl.ins_en && ge) begin
			entry_q <= prev_ge ? left_entry : key;
		end else if (ctrl.rem_en && (hit_before || match)) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule
